@@ sv/ps2mt_pkg.sv @@
// Package for the PS/2 mouse packet tracker: action codes, flag-bit
// positions, reset values and the cursor state struct.
// No dependencies.
package ps2mt_pkg;

	typedef enum logic [1:0] {
		ACT_BYTE    = 2'd0,
		ACT_POLL    = 2'd1,
		ACT_RESTART = 2'd2
	} action_t;

	// Bit positions in the flags byte (byte 0 of a packet)
	localparam int unsigned FLAG_ALIGN_BIT = 3;
	localparam int unsigned FLAG_X_OVF_BIT = 6;
	localparam int unsigned FLAG_Y_OVF_BIT = 7;
	localparam int unsigned BUTTON_W       = 3;

	localparam logic [7:0] MAX_COLUMN_RST = 8'd79;
	localparam logic [7:0] MAX_LINE_RST   = 8'd24;
	localparam logic [7:0] COLUMN_RST     = 8'd40;
	localparam logic [7:0] ROW_RST        = 8'd12;

	localparam logic CFG_MAX_COLUMN = 1'b0;
	localparam logic CFG_MAX_LINE   = 1'b1;

	typedef struct packed {
		logic [7:0]          column;
		logic [7:0]          row;
		logic [BUTTON_W-1:0] buttons;
	} cursor_t;

endpackage

@@ sv/ps2mt_req_if.sv @@
// Request channel of the PS/2 mouse packet tracker (action + mouse byte).
// Depends on ps2mt_pkg.
interface ps2mt_req_if;
	import ps2mt_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

@@ sv/ps2mt_rsp_if.sv @@
// Response channel of the PS/2 mouse packet tracker (poll results).
// Depends on ps2mt_pkg.
interface ps2mt_rsp_if;
	import ps2mt_pkg::*;

	logic                valid;
	logic                ready;
	logic                fresh;
	logic [7:0]          cursor_column;
	logic [7:0]          cursor_row;
	logic [BUTTON_W-1:0] button_bits;

	modport source (output valid, output fresh, output cursor_column, output cursor_row,
		output button_bits, input ready);
	modport sink   (input valid, input fresh, input cursor_column, input cursor_row,
		input button_bits, output ready);
endinterface

@@ sv/ps2mt_apply.sv @@
// Packet apply logic: overflow masking, signed delta add (X) and subtract (Y), clamp to 0..max.
// Depends on ps2mt_pkg.
module ps2mt_apply (
	input  logic [7:0]        flags,
	input  logic [7:0]        dx_byte,
	input  logic [7:0]        dy_byte,
	input  ps2mt_pkg::cursor_t cur,
	input  logic [7:0]        max_column,
	input  logic [7:0]        max_line,
	output ps2mt_pkg::cursor_t nxt
);
	import ps2mt_pkg::*;

	logic signed [9:0] dx;
	logic signed [9:0] dy;
	logic signed [9:0] col_sum;
	logic signed [9:0] row_sum;

	function automatic logic [7:0] clamp_cell(input logic signed [9:0] v,
		input logic [7:0] top);
		logic [7:0] r;
		if (v[9]) begin
			r = 8'd0;
		end else if (v[8:0] > {1'b0, top}) begin
			r = top;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	always_comb begin
		dx = flags[FLAG_X_OVF_BIT] ? 10'sd0 : signed'({{2{dx_byte[7]}}, dx_byte});
		dy = flags[FLAG_Y_OVF_BIT] ? 10'sd0 : signed'({{2{dy_byte[7]}}, dy_byte});
		col_sum = signed'({2'b00, cur.column}) + dx;
		row_sum = signed'({2'b00, cur.row}) - dy;
		nxt.column  = clamp_cell(col_sum, max_column);
		nxt.row     = clamp_cell(row_sum, max_line);
		nxt.buttons = flags[BUTTON_W-1:0];
	end

endmodule

@@ sv/ps2_mouse_packet_tracker.sv @@
// PS/2 mouse packet tracker, top level. A poll beat enters the input register,
// then is loaded into the result register once the result slot is free or being emptied.
// Throughput: one beat per cycle; the input register drains whenever it does not
// hold a poll blocked behind an untaken result.
// Reset (arst_n low): framing at byte 0, first packet skipped, cursor at 40/12,
// buttons and fresh flag clear, limits 79/24. Held packet bytes are not reset.
// Depends on ps2mt_pkg, ps2mt_req_if, ps2mt_rsp_if, ps2mt_apply.
module ps2_mouse_packet_tracker (
	input  logic        clk,
	input  logic        arst_n,
	ps2mt_req_if.sink   req,
	ps2mt_rsp_if.source rsp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import ps2mt_pkg::*;

	// Configuration registers
	logic [7:0] max_column_q;
	logic [7:0] max_line_q;

	// Input register stage
	logic       valid_s1;
	action_t    action_s1;
	logic [7:0] byte_s1;

	// Tracker state
	logic [1:0] byte_pos_q,  byte_pos_d;
	logic [7:0] held0_q,     held0_d;
	logic [7:0] held1_q,     held1_d;
	logic       skip_q,      skip_d;
	logic       fresh_q,     fresh_d;
	cursor_t    cur_q,       cur_d;
	cursor_t    cur_applied;

	// Result register
	logic       out_valid_q;
	logic       out_fresh_q;
	cursor_t    out_cur_q;

	logic       go;
	logic       is_poll;
	logic       take_poll;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_column_q <= MAX_COLUMN_RST;
			max_line_q   <= MAX_LINE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_COLUMN: max_column_q <= cfg_data;
				CFG_MAX_LINE:   max_line_q   <= cfg_data;
				default:        max_column_q <= max_column_q;
			endcase
		end
	end

	// A poll may only leave the input stage if the result slot is free or
	// being emptied this cycle; everything else moves unconditionally.
	assign is_poll   = (action_s1 == ACT_POLL);
	assign go        = valid_s1 && (!is_poll || !out_valid_q || rsp.ready);
	assign take_poll = go && is_poll;
	assign req.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			action_s1 <= action_t'(req.action);
			byte_s1   <= req.rx_byte;
		end
	end

	// Delta add and clamp for the packet completed by byte_s1
	ps2mt_apply u_apply (
		.flags      (held0_q),
		.dx_byte    (held1_q),
		.dy_byte    (byte_s1),
		.cur        (cur_q),
		.max_column (max_column_q),
		.max_line   (max_line_q),
		.nxt        (cur_applied)
	);

	always_comb begin
		byte_pos_d = byte_pos_q;
		held0_d    = held0_q;
		held1_d    = held1_q;
		skip_d     = skip_q;
		fresh_d    = fresh_q;
		cur_d      = cur_q;
		if (go) begin
			unique case (action_s1)
				ACT_BYTE: begin
					unique case (byte_pos_q)
						2'd0: begin
							// resync: only a byte with the align bit opens a packet
							if (byte_s1[FLAG_ALIGN_BIT]) begin
								held0_d    = byte_s1;
								byte_pos_d = 2'd1;
							end
						end
						2'd1: begin
							held1_d    = byte_s1;
							byte_pos_d = 2'd2;
						end
						default: begin
							byte_pos_d = 2'd0;
							if (skip_q) begin
								skip_d = 1'b0;
							end else begin
								cur_d   = cur_applied;
								fresh_d = 1'b1;
							end
						end
					endcase
				end
				ACT_POLL: begin
					fresh_d = 1'b0;
				end
				ACT_RESTART: begin
					byte_pos_d = 2'd0;
					fresh_d    = 1'b0;
					skip_d     = 1'b1;
				end
				default: begin
					// unused code: no state change
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= 2'd0;
			skip_q      <= 1'b1;
			fresh_q     <= 1'b0;
			cur_q       <= '{column: COLUMN_RST, row: ROW_RST, buttons: '0};
		end else begin
			byte_pos_q  <= byte_pos_d;
			skip_q      <= skip_d;
			fresh_q     <= fresh_d;
			cur_q       <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		held0_q <= held0_d;
		held1_q <= held1_d;
	end

	// Result register: loaded by a poll, emptied when the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_poll) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_poll) begin
			out_fresh_q <= fresh_q;
			out_cur_q   <= cur_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.fresh         = out_fresh_q;
	assign rsp.cursor_column = out_cur_q.column;
	assign rsp.cursor_row    = out_cur_q.row;
	assign rsp.button_bits   = out_cur_q.buttons;

endmodule
